>>> src/ntidw_pkg.sv
// Shared types and constants of the nearest three inverse distance weighting block.
`timescale 1ns / 1ps
`default_nettype none
package ntidw_pkg;

  localparam int unsigned DIST_W = 48;
  localparam int unsigned ST_W   = 8;
  localparam int unsigned W_W    = 17;
  localparam int unsigned RANK_W = 2;
  localparam int unsigned HALF_W = DIST_W / 2;
  localparam int unsigned PROD_W = 2 * DIST_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned REM_W  = SUM_W + FRAC_W;

  // Stations at or above this number are skipped.
  localparam int unsigned MAX_STATIONS = 256;

  localparam logic [DIST_W-1:0] CUTOFF_RESET = 48'd256000000000;
  localparam logic [W_W-1:0]    ONE_Q16      = 17'h10000;

  // Configuration register index, taken from paddr[3].
  localparam logic REG_CUTOFF = 1'b0;

  // One grid point handed from the front to the back.
  typedef struct packed {
    logic                       ok;
    logic [2:0][DIST_W-1:0]     dst;
    logic [2:0][ST_W-1:0]       stn;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

>>> src/ntidw_front.sv
// Front end: accepts distance requests and keeps the three nearest stations.
`timescale 1ns / 1ps
`default_nettype none
module ntidw_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ntidw_pkg::DIST_W-1:0] in_distance_i,
  input  wire logic [ntidw_pkg::ST_W-1:0]   in_station_number_i,
  input  wire logic                         in_final_station_i,
  input  wire logic [ntidw_pkg::DIST_W-1:0] cutoff_i,
  input  wire ntidw_pkg::q_stat_t           q_stat_i,
  output logic                              push_o,
  output ntidw_pkg::job_t                   job_o
);

  logic [2:0][ntidw_pkg::DIST_W-1:0] best_d_q, best_d_d;
  logic [2:0][ntidw_pkg::ST_W-1:0]   best_s_q, best_s_d;
  logic [1:0]                        cnt_q, cnt_d;
  logic [2:0]                        le;
  logic                              qualifies;
  logic                              ins;
  logic                              accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    qualifies = ({1'b0, in_station_number_i} < 9'(ntidw_pkg::MAX_STATIONS)) &&
                (in_distance_i < cutoff_i);
    for (int i = 0; i < 3; i++) begin
      le[i] = (2'(i) < cnt_q) && (best_d_q[i] <= in_distance_i);
    end
    // The kept entries are sorted, so le is a prefix and the new entry lands
    // at the first position that is not at or below it.
    ins      = qualifies && !le[2];
    best_d_d = best_d_q;
    best_s_d = best_s_q;
    if (ins) begin
      for (int i = 0; i < 3; i++) begin
        if (!le[i]) begin
          if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
            best_d_d[i] = in_distance_i;
            best_s_d[i] = in_station_number_i;
          end else begin
            best_d_d[i] = best_d_q[(i == 0) ? 0 : i - 1];
            best_s_d[i] = best_s_q[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end
    cnt_d = (ins && cnt_q != 2'd3) ? cnt_q + 2'd1 : cnt_q;
  end

  assign push_o = accept && in_final_station_i;
  assign job_o  = ntidw_pkg::job_t'{ok: (cnt_d == 2'd3), dst: best_d_d, stn: best_s_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_d_q <= '1;
      best_s_q <= '0;
      cnt_q    <= '0;
    end else if (accept) begin
      if (in_final_station_i) begin
        best_d_q <= '1;
        best_s_q <= '0;
        cnt_q    <= '0;
      end else begin
        best_d_q <= best_d_d;
        best_s_q <= best_s_d;
        cnt_q    <= cnt_d;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/ntidw_queue.sv
// Short job queue between the front end and the weight unit.
`timescale 1ns / 1ps
`default_nettype none
module ntidw_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ntidw_pkg::job_t push_job_i,
  input  wire logic            pop_i,
  output ntidw_pkg::job_t      pop_job_o,
  output ntidw_pkg::q_stat_t   stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ntidw_pkg::job_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign pop_job_o = mem_q[rd_ptr_q];
  assign stat_o    = ntidw_pkg::q_stat_t'{full: (cnt_q == CNT_W'(DEPTH)),
                                          empty: (cnt_q == '0)};

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/ntidw_back.sv
// Back end: products, sum and bit-serial division for the first two weights; the third is one minus both.
`timescale 1ns / 1ps
`default_nettype none
module ntidw_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ntidw_pkg::q_stat_t            q_stat_i,
  input  wire ntidw_pkg::job_t               job_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ntidw_pkg::ST_W-1:0]         out_chosen_station_o,
  output logic [ntidw_pkg::W_W-1:0]          out_weight_o,
  output logic [ntidw_pkg::RANK_W-1:0]       out_rank_o,
  output logic                               out_last_result_o,
  output logic                               out_too_few_stations_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL,
    ST_SUM0,
    ST_SUM1,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam int unsigned DW = ntidw_pkg::DIST_W;
  localparam int unsigned HW = ntidw_pkg::HALF_W;
  localparam int unsigned PW = ntidw_pkg::PROD_W;
  localparam int unsigned SW = ntidw_pkg::SUM_W;
  localparam int unsigned FW = ntidw_pkg::FRAC_W;
  localparam int unsigned RW = ntidw_pkg::REM_W;
  localparam int unsigned WW = ntidw_pkg::W_W;
  // Three products of four partial products each.
  localparam logic [3:0] MUL_STEPS = 4'd12;

  state_e                       state_q;
  logic [2:0][DW-1:0]           e_q;
  logic [2:0][ntidw_pkg::ST_W-1:0] st_q;
  logic [3:0]                   mcnt_q;
  logic [2*HW-1:0]              pp_q;
  logic [3:0]                   pp_sel_q;
  logic                         pp_vld_q;
  logic [2:0][PW-1:0]           n_q;
  logic [SW-1:0]                s_q;
  logic [RW-1:0]                rem_q;
  logic [RW-1:0]                den_q;
  logic [4:0]                   bit_q;
  logic                         wsel_q;
  logic [WW-1:0]                quo_q;
  logic [1:0][WW-1:0]           w_q;
  logic [1:0]                   rank_q;

  logic                         out_valid_q;
  logic [ntidw_pkg::ST_W-1:0]   out_st_q;
  logic [WW-1:0]                out_w_q;
  logic [ntidw_pkg::RANK_W-1:0] out_rank_q;
  logic                         out_last_q;
  logic                         out_err_q;

  logic [DW-1:0]                op_a, op_b;
  logic [HW-1:0]                a_h, b_h;
  logic [2*HW-1:0]              pp_d;
  logic [PW-1:0]                addend;
  logic [SW-1:0]                sum_full;
  logic                         ge;
  logic [RW-1:0]                rem_diff;
  logic [WW-1:0]                quo_next;
  logic [WW-1:0]                w_third;
  logic                         out_free;
  logic                         out_load;

  assign pop_o = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = out_free && ((state_q == ST_ERR) || (state_q == ST_OUT));

  always_comb begin
    case (mcnt_q[3:2])
      2'd0:    begin op_a = e_q[1]; op_b = e_q[2]; end
      2'd1:    begin op_a = e_q[0]; op_b = e_q[2]; end
      default: begin op_a = e_q[0]; op_b = e_q[1]; end
    endcase
    a_h = mcnt_q[1] ? op_a[DW-1:HW] : op_a[HW-1:0];
    b_h = mcnt_q[0] ? op_b[DW-1:HW] : op_b[HW-1:0];
    pp_d = a_h * b_h;
    case (pp_sel_q[1:0])
      2'd0:    addend = {{(PW-2*HW){1'b0}}, pp_q};
      2'd3:    addend = {{(PW-2*HW){1'b0}}, pp_q} << (2 * HW);
      default: addend = {{(PW-2*HW){1'b0}}, pp_q} << HW;
    endcase
    sum_full = s_q + {2'b0, n_q[2]};
    ge       = (rem_q >= den_q);
    rem_diff = rem_q - den_q;
    quo_next = {quo_q[WW-2:0], ge};
    w_third  = ntidw_pkg::ONE_Q16 - w_q[0] - w_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mcnt_q      <= '0;
      pp_vld_q    <= 1'b0;
      bit_q       <= '0;
      wsel_q      <= 1'b0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_stat_i.empty) begin
            for (int i = 0; i < 3; i++) begin
              e_q[i] <= (job_i.dst[i] == '0) ? DW'(1) : job_i.dst[i];
            end
            st_q     <= job_i.stn;
            n_q      <= '0;
            mcnt_q   <= '0;
            pp_vld_q <= 1'b0;
            state_q  <= job_i.ok ? ST_MUL : ST_ERR;
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_st_q    <= '0;
            out_w_q     <= '0;
            out_rank_q  <= '0;
            out_last_q  <= 1'b0;
            out_err_q   <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_MUL: begin
          // Partial products are registered and added in the next cycle.
          if (mcnt_q != MUL_STEPS) begin
            pp_q     <= pp_d;
            pp_sel_q <= mcnt_q;
            mcnt_q   <= mcnt_q + 4'd1;
          end else begin
            state_q <= ST_SUM0;
          end
          pp_vld_q <= (mcnt_q != MUL_STEPS);
          if (pp_vld_q) begin
            n_q[pp_sel_q[3:2]] <= n_q[pp_sel_q[3:2]] + addend;
          end
        end
        ST_SUM0: begin
          s_q     <= {2'b0, n_q[0]} + {2'b0, n_q[1]};
          state_q <= ST_SUM1;
        end
        ST_SUM1: begin
          s_q     <= sum_full;
          den_q   <= {sum_full, {FW{1'b0}}};
          rem_q   <= {2'b0, n_q[0], {FW{1'b0}}};
          quo_q   <= '0;
          bit_q   <= 5'(FW);
          wsel_q  <= 1'b0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          // One quotient bit per cycle, divisor shifted down each step.
          if (bit_q == '0) begin
            w_q[wsel_q] <= quo_next;
            if (!wsel_q) begin
              wsel_q <= 1'b1;
              rem_q  <= {2'b0, n_q[1], {FW{1'b0}}};
              den_q  <= {s_q, {FW{1'b0}}};
              quo_q  <= '0;
              bit_q  <= 5'(FW);
            end else begin
              rank_q  <= '0;
              state_q <= ST_OUT;
            end
          end else begin
            if (ge) begin
              rem_q <= rem_diff;
            end
            den_q <= den_q >> 1;
            quo_q <= quo_next;
            bit_q <= bit_q - 5'd1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_st_q    <= st_q[rank_q];
            out_rank_q  <= rank_q;
            out_last_q  <= (rank_q == 2'd2);
            out_err_q   <= 1'b0;
            case (rank_q)
              2'd0:    out_w_q <= w_q[0];
              2'd1:    out_w_q <= w_q[1];
              default: out_w_q <= w_third;
            endcase
            if (rank_q == 2'd2) begin
              state_q <= ST_IDLE;
            end else begin
              rank_q <= rank_q + 2'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_chosen_station_o   = out_st_q;
  assign out_weight_o           = out_w_q;
  assign out_rank_o             = out_rank_q;
  assign out_last_result_o      = out_last_q;
  assign out_too_few_stations_o = out_err_q;

endmodule
`default_nettype wire

>>> src/nearest_three_inverse_distance_weights_top.sv
// Top level: configuration port, front end, job queue and weight unit.
// The front end takes one distance request per cycle while the job queue is not full;
// a grid point's final request queues a job, and the weight unit delivers its first
// result after 12 partial products on one 24x24 multiplier, two sums and 34 division
// steps, then one result per cycle unless the output stalls. Too few stations give one
// error result. The back end takes a job only when idle; QUEUE_DEPTH jobs may wait.
// Reset empties the kept stations and the queue and sets the cutoff to 256000000000.
`timescale 1ns / 1ps
`default_nettype none
module nearest_three_inverse_distance_weights_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [3:0]                   paddr,
  input  wire logic [63:0]                  pwdata,
  output logic [63:0]                       prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ntidw_pkg::DIST_W-1:0] in_distance_i,
  input  wire logic [ntidw_pkg::ST_W-1:0]   in_station_number_i,
  input  wire logic                         in_final_station_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [ntidw_pkg::ST_W-1:0]        out_chosen_station_o,
  output logic [ntidw_pkg::W_W-1:0]         out_weight_o,
  output logic [ntidw_pkg::RANK_W-1:0]      out_rank_o,
  output logic                              out_last_result_o,
  output logic                              out_too_few_stations_o
);

  logic [ntidw_pkg::DIST_W-1:0] cutoff_q;
  logic                         cfg_wr;
  logic                         push;
  logic                         pop;
  ntidw_pkg::job_t              push_job;
  ntidw_pkg::job_t              pop_job;
  ntidw_pkg::q_stat_t           q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[3] == ntidw_pkg::REG_CUTOFF);
  assign prdata = (paddr[3] == ntidw_pkg::REG_CUTOFF) ?
                  {{(64 - ntidw_pkg::DIST_W){1'b0}}, cutoff_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= ntidw_pkg::CUTOFF_RESET;
    end else if (cfg_wr) begin
      cutoff_q <= pwdata[ntidw_pkg::DIST_W-1:0];
    end
  end

  ntidw_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_distance_i       (in_distance_i),
    .in_station_number_i (in_station_number_i),
    .in_final_station_i  (in_final_station_i),
    .cutoff_i            (cutoff_q),
    .q_stat_i            (q_stat),
    .push_o              (push),
    .job_o               (push_job)
  );

  ntidw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .stat_o     (q_stat)
  );

  ntidw_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .q_stat_i               (q_stat),
    .job_i                  (pop_job),
    .pop_o                  (pop),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_chosen_station_o   (out_chosen_station_o),
    .out_weight_o           (out_weight_o),
    .out_rank_o             (out_rank_o),
    .out_last_result_o      (out_last_result_o),
    .out_too_few_stations_o (out_too_few_stations_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_too_few_stations_o |->
      out_weight_o == '0 && out_chosen_station_o == '0 &&
      out_rank_o == '0 && !out_last_result_o)
    else $error("error result carries nonzero fields");

  a_last_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_too_few_stations_o |-> (out_last_result_o == (out_rank_o == 2'd2)))
    else $error("last result mark does not match the third rank");

endmodule
`default_nettype wire

>>> tb/nearest_three_inverse_distance_weights_top_tb.sv
// Testbench of the nearest three inverse distance weights block with a self-checking predictor.
`timescale 1ns / 1ps
module nearest_three_inverse_distance_weights_top_tb;

  localparam int unsigned DIST_W = ntidw_pkg::DIST_W;
  localparam int unsigned ST_W   = ntidw_pkg::ST_W;
  localparam int unsigned W_W    = ntidw_pkg::W_W;
  localparam int unsigned RANK_W = ntidw_pkg::RANK_W;
  localparam int unsigned SUM_W  = ntidw_pkg::SUM_W;
  localparam int unsigned REM_W  = ntidw_pkg::REM_W;
  localparam int unsigned FRAC_W = ntidw_pkg::FRAC_W;

  localparam logic [3:0] CUTOFF_ADDR = 4'h0;
  // Byte address of the unmapped second register slot.
  localparam logic [3:0] SPARE_ADDR  = 4'h8;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam int IDLE_PCT  = 17;
  localparam int HOLD_SPAN = 400;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [DIST_W-1:0] dst;
    logic [ST_W-1:0]   stn;
    logic              fin;
  } dist_req_t;

  typedef struct {
    logic [ST_W-1:0]   stn;
    logic [W_W-1:0]    weight;
    logic [RANK_W-1:0] rank;
    logic              last;
    logic              too_few;
  } weight_res_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [63:0]       pwdata;
  logic [63:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [DIST_W-1:0] in_distance_i;
  logic [ST_W-1:0]   in_station_number_i;
  logic              in_final_station_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ST_W-1:0]   out_chosen_station_o;
  logic [W_W-1:0]    out_weight_o;
  logic [RANK_W-1:0] out_rank_o;
  logic              out_last_result_o;
  logic              out_too_few_stations_o;

  nearest_three_inverse_distance_weights_top uut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .in_distance_i          (in_distance_i),
    .in_station_number_i    (in_station_number_i),
    .in_final_station_i     (in_final_station_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_chosen_station_o   (out_chosen_station_o),
    .out_weight_o           (out_weight_o),
    .out_rank_o             (out_rank_o),
    .out_last_result_o      (out_last_result_o),
    .out_too_few_stations_o (out_too_few_stations_o)
  );

  dist_req_t   dist_requests[$];
  weight_res_t weight_results_due[$];

  // Predictor state: the cutoff register and the three kept stations of the open grid point.
  logic [DIST_W-1:0] cutoff_reg;
  logic [DIST_W-1:0] kept_dist [3];
  logic [ST_W-1:0]   kept_stn [3];
  int                kept_count;

  int   err_count;
  bit   in_taken;
  bit   steady;
  bit   hold_request;
  bit   hold_spent;
  int   hold_left;
  dist_req_t next_req;

  task automatic flag_error(input string msg);
    err_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic clear_point();
    for (int i = 0; i < 3; i++) begin
      kept_dist[i] = DIST_MAX;
      kept_stn[i] = '0;
    end
    kept_count = 0;
  endtask

  // floor(65536 * num / den) at full width.
  function automatic logic [W_W-1:0] q16_share(input logic [SUM_W-1:0] num,
                                               input logic [SUM_W-1:0] den);
    logic [REM_W-1:0] scaled;
    logic [REM_W-1:0] quo;
    scaled = num;
    scaled = scaled << FRAC_W;
    quo = scaled / den;
    return quo[W_W-1:0];
  endfunction

  task automatic take_distance(input logic [DIST_W-1:0] d, input logic [ST_W-1:0] st,
                               input logic fin);
    int pos;
    logic [DIST_W-1:0] e [3];
    logic [SUM_W-1:0] n1, n2, n3, total;
    logic [W_W-1:0] w [3];
    weight_res_t res;
    if (int'(st) < ntidw_pkg::MAX_STATIONS && d < cutoff_reg) begin
      pos = 0;
      while (pos < kept_count && kept_dist[pos] <= d) pos++;
      if (pos < 3) begin
        for (int i = 2; i > pos; i--) begin
          kept_dist[i] = kept_dist[i-1];
          kept_stn[i] = kept_stn[i-1];
        end
        kept_dist[pos] = d;
        kept_stn[pos] = st;
        if (kept_count < 3) kept_count++;
      end
    end
    if (!fin) return;
    if (kept_count < 3) begin
      res = '{stn: '0, weight: '0, rank: '0, last: 1'b0, too_few: 1'b1};
      weight_results_due = {weight_results_due, res};
    end else begin
      // A zero distance ranks as zero but weighs as one least step.
      for (int i = 0; i < 3; i++) e[i] = (kept_dist[i] == '0) ? DIST_W'(1) : kept_dist[i];
      n1 = e[1] * e[2];
      n2 = e[0] * e[2];
      n3 = e[0] * e[1];
      total = n1 + n2 + n3;
      w[0] = q16_share(n1, total);
      w[1] = q16_share(n2, total);
      w[2] = ntidw_pkg::ONE_Q16 - w[0] - w[1];
      for (int i = 0; i < 3; i++) begin
        res = '{stn: kept_stn[i], weight: w[i], rank: RANK_W'(i), last: (i == 2),
                too_few: 1'b0};
        weight_results_due = {weight_results_due, res};
      end
    end
    clear_point();
  endtask

  function automatic logic [DIST_W-1:0] pick_distance(input logic [DIST_W-1:0] prev);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return raw[DIST_W-1:0];
      1: return DIST_W'($urandom_range(0, 3));
      2: return cutoff_reg + DIST_W'($urandom_range(0, 2)) - DIST_W'(1);
      3: return prev;
      default: return (cutoff_reg == '0) ? raw[DIST_W-1:0] : raw[DIST_W-1:0] % cutoff_reg;
    endcase
  endfunction

  task automatic queue_req(input logic [DIST_W-1:0] d, input logic [ST_W-1:0] st,
                           input logic fin);
    dist_req_t r;
    r = '{dst: d, stn: st, fin: fin};
    dist_requests = {dist_requests, r};
  endtask

  // Grid points of random size; a few are too short or long to stress the sorting.
  task automatic queue_random_points(input int item_goal);
    int queued;
    int n;
    logic [DIST_W-1:0] d;
    queued = 0;
    d = '0;
    while (queued < item_goal) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(1, 2);
        1: n = $urandom_range(9, 24);
        default: n = $urandom_range(3, 6);
      endcase
      for (int i = 0; i < n; i++) begin
        d = pick_distance(d);
        queue_req(d, ST_W'($urandom_range(0, 255)), i == n - 1);
      end
      queued += n;
    end
  endtask

  task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [63:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (!wr && prdata[DIST_W-1:0] !== cutoff_reg)
      flag_error($sformatf("cutoff read back %h, expected %h", prdata[DIST_W-1:0], cutoff_reg));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_cutoff(input logic [DIST_W-1:0] value);
    apb_access(1'b1, CUTOFF_ADDR, {16'h0, value});
    cutoff_reg = value;
    apb_access(1'b0, CUTOFF_ADDR, '0);
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (dist_requests.size() != 0 || in_valid_i || weight_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    in_distance_i = '0;
    in_station_number_i = '0;
    in_final_station_i = 1'b0;
    out_stall_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

  // Request driver: a new request only after the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (dist_requests.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_req = dist_requests.pop_front();
        in_distance_i <= next_req.dst;
        in_station_number_i <= next_req.stn;
        in_final_station_i <= next_req.fin;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off that backs up the block.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_request && !hold_spent) begin
      hold_left = HOLD_SPAN;
      hold_spent = 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    weight_res_t exp_res;
    in_taken = in_valid_i && !in_stall_o;
    if (rst_ni && in_taken) take_distance(in_distance_i, in_station_number_i, in_final_station_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (weight_results_due.size() == 0) begin
        flag_error($sformatf("unexpected result station %0d weight %0d rank %0d",
                             out_chosen_station_o, out_weight_o, out_rank_o));
      end else begin
        exp_res = weight_results_due.pop_front();
        if (out_chosen_station_o !== exp_res.stn)
          flag_error($sformatf("chosen_station %0d, expected %0d",
                               out_chosen_station_o, exp_res.stn));
        if (out_weight_o !== exp_res.weight)
          flag_error($sformatf("weight %0d, expected %0d", out_weight_o, exp_res.weight));
        if (out_rank_o !== exp_res.rank)
          flag_error($sformatf("rank %0d, expected %0d", out_rank_o, exp_res.rank));
        if (out_last_result_o !== exp_res.last)
          flag_error($sformatf("last_result %b, expected %b", out_last_result_o, exp_res.last));
        if (out_too_few_stations_o !== exp_res.too_few)
          flag_error($sformatf("too_few_stations %b, expected %b",
                               out_too_few_stations_o, exp_res.too_few));
      end
    end
  end

  initial begin
    err_count = 0;
    steady = 1'b0;
    hold_request = 1'b0;
    hold_spent = 1'b0;
    hold_left = 0;
    in_taken = 1'b0;
    cutoff_reg = ntidw_pkg::CUTOFF_RESET;
    clear_point();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero distance, smallest nonzero distance and the largest one below the cutoff.
    queue_req('0, 8'd0, 1'b0);
    queue_req(DIST_W'(1), 8'd255, 1'b0);
    queue_req(ntidw_pkg::CUTOFF_RESET - 1, 8'd7, 1'b1);
    // At the cutoff and all ones are skipped, so too few stations remain.
    queue_req(ntidw_pkg::CUTOFF_RESET, 8'd1, 1'b0);
    queue_req(DIST_MAX, 8'd2, 1'b0);
    queue_req(DIST_W'(5), 8'd3, 1'b1);
    // Ties keep arrival order; a repeated station number counts again.
    queue_req(DIST_W'(100), 8'd10, 1'b0);
    queue_req(DIST_W'(100), 8'd11, 1'b0);
    queue_req(DIST_W'(100), 8'd10, 1'b0);
    queue_req(DIST_W'(100), 8'd12, 1'b0);
    queue_req(DIST_W'(50), 8'd13, 1'b1);
    queue_req(DIST_W'(7), 8'd9, 1'b1);
    queue_req(DIST_W'(1), 8'd1, 1'b0);
    queue_req(DIST_W'(1), 8'd2, 1'b0);
    queue_req(DIST_W'(1), 8'd3, 1'b1);
    queue_random_points(40);
    wait_idle();

    // Widest cutoff; a write to the unmapped slot must leave it alone.
    set_cutoff(DIST_MAX);
    apb_access(1'b1, SPARE_ADDR, 64'h0);
    apb_access(1'b0, CUTOFF_ADDR, '0);
    queue_req(DIST_MAX - 1, 8'd200, 1'b0);
    queue_req('0, 8'd201, 1'b0);
    queue_req(DIST_MAX, 8'd203, 1'b0);
    queue_req(DIST_MAX - 2, 8'd202, 1'b1);
    steady = 1'b1;
    queue_random_points(60);
    wait_idle();
    steady = 1'b0;

    set_cutoff('0);
    queue_random_points(25);
    wait_idle();

    set_cutoff(DIST_W'(1));
    queue_random_points(25);
    wait_idle();

    set_cutoff(DIST_W'({$urandom, $urandom} >> $urandom_range(0, 20)));
    hold_request = 1'b1;
    queue_random_points(70);
    wait_idle();

    set_cutoff(ntidw_pkg::CUTOFF_RESET);
    queue_random_points(60);
    wait_idle();

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
